@@ rtl/nbt_stream_tokenizer_top_macros.svh @@
// Assertion macros for the tag tokenizer checker.
// No dependencies; included by the checker file only.
`ifndef NBT_STREAM_TOKENIZER_TOP_MACROS_SVH
`define NBT_STREAM_TOKENIZER_TOP_MACROS_SVH
// Property checked while out of reset.
`define NBT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every edge, reset included.
`define NBT_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ rtl/nbt_pkg.sv @@
// Shared types and codes of the tag tokenizer.
// No dependencies.
`default_nettype none
package nbt_pkg;
  localparam int MAX_DEPTH_DEF = 32;
  localparam logic [5:0] DEPTH_RESET = 6'd32;

  // byte roles
  localparam logic [3:0] ROLE_TYPE     = 4'd0;
  localparam logic [3:0] ROLE_NAMELEN  = 4'd1;
  localparam logic [3:0] ROLE_NAME     = 4'd2;
  localparam logic [3:0] ROLE_SCALAR   = 4'd3;
  localparam logic [3:0] ROLE_STRLEN   = 4'd4;
  localparam logic [3:0] ROLE_STR      = 4'd5;
  localparam logic [3:0] ROLE_LISTTYPE = 4'd6;
  localparam logic [3:0] ROLE_COUNT    = 4'd7;
  localparam logic [3:0] ROLE_ELEM     = 4'd8;
  localparam logic [3:0] ROLE_CEND     = 4'd9;
  localparam logic [3:0] ROLE_IGNORED  = 4'd10;

  // error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_TYPE   = 3'd1;
  localparam logic [2:0] ERR_NEG    = 3'd2;
  localparam logic [2:0] ERR_DEEP   = 3'd3;
  localparam logic [2:0] ERR_TRUNC  = 3'd4;

  // tag types
  localparam logic [3:0] T_END      = 4'd0;
  localparam logic [3:0] T_BYTE     = 4'd1;
  localparam logic [3:0] T_SHORT    = 4'd2;
  localparam logic [3:0] T_INT      = 4'd3;
  localparam logic [3:0] T_LONG     = 4'd4;
  localparam logic [3:0] T_FLOAT    = 4'd5;
  localparam logic [3:0] T_DOUBLE   = 4'd6;
  localparam logic [3:0] T_BARRAY   = 4'd7;
  localparam logic [3:0] T_STRING   = 4'd8;
  localparam logic [3:0] T_LIST     = 4'd9;
  localparam logic [3:0] T_COMPOUND = 4'd10;
  localparam logic [3:0] T_IARRAY   = 4'd11;
  localparam logic [3:0] T_LARRAY   = 4'd12;

  // open frame: list flag, element type, elements not yet started
  typedef struct packed {
    logic        is_list;
    logic [3:0]  etype;
    logic [30:0] left;
  } frame_t;

  // classified input byte
  typedef struct packed {
    logic [7:0] data;
    logic       eod;
    logic       is_end;
    logic       bad_type;
  } item_t;

  // one finished result
  typedef struct packed {
    logic [31:0] position;
    logic [3:0]  role;
    logic [3:0]  ttype;
    logic [5:0]  level;
    logic [63:0] value;
    logic        vdone;
    logic        doc_done;
    logic [2:0]  err;
  } result_t;
endpackage
`default_nettype wire

@@ rtl/nbt_front.sv @@
// Front stage: accepts bytes, classifies them, queues two entries.
// Depends on nbt_pkg.
`default_nettype none
module nbt_front import nbt_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  output logic            q_valid,
  output item_t           q_item,
  input  wire logic       q_pop
);
  item_t      slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  item_t      cls;

  // classify the byte on entry
  always_comb begin
    cls.data     = in_tdata;
    cls.eod      = in_tlast;
    cls.is_end   = (in_tdata == 8'd0);
    cls.bad_type = (in_tdata > 8'd12);
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= cls;
  end
endmodule
`default_nettype wire

@@ rtl/nbt_parser.sv @@
// Back stage: grammar sequencer with frame stack memory and result register.
// Depends on nbt_pkg.
`default_nettype none
module nbt_parser import nbt_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_wdata,
  input  wire logic       q_valid,
  input  wire item_t      q_item,
  output logic            q_pop,
  output logic            res_valid,
  output result_t         res,
  input  wire logic       res_ready
);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW = $clog2(MAX_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_ROOT, PH_CHILD, PH_NAMELEN, PH_NAME, PH_SCALAR, PH_STRLEN, PH_STR,
    PH_LISTTYPE, PH_COUNT, PH_ELEM, PH_HALT
  } phase_t;
  typedef enum logic [1:0] {S_IDLE, S_FIN, S_WAIT, S_BEGIN} st_t;

  function automatic logic [3:0] elem_size(input logic [3:0] t);
    elem_size = (t == T_BARRAY) ? 4'd1 : ((t == T_IARRAY) ? 4'd4 : 4'd8);
  endfunction

  // frame stack below the cached top frame
  frame_t stack_mem [MAX_DEPTH];
  frame_t rd_data;
  logic   mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  frame_t mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) stack_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= stack_mem[mem_ra];
  end

  st_t     st_r, st_nxt;
  phase_t  ph_r, ph_nxt;
  logic [LW-1:0] level_r, level_nxt, lvlm1, lvlm2;
  frame_t  top_r, top_nxt;
  logic [3:0]  cur_r, cur_nxt, nbl_r, nbl_nxt, nbl_dec;
  logic [31:0] run_r, run_nxt, run_dec;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [5:0]  depth_r, depth_nxt;
  // fields held while a byte finishes
  logic [31:0] ppos_r, ppos_nxt;
  logic [3:0]  prole_r, prole_nxt, ptype_r, ptype_nxt;
  logic [63:0] pval_r, pval_nxt;
  logic        pvd_r, pvd_nxt, peod_r, peod_nxt;
  logic        ov_r, ov_nxt;
  result_t     res_r, res_nxt;

  logic        start, done, doc, full;
  logic [2:0]  e, errv;
  logic [7:0]  b;
  logic [63:0] acc16, acc32;
  int          lim_i;

  assign b     = q_item.data;
  assign lvlm1 = level_r - 1'b1;
  assign lvlm2 = lvlm1 - 1'b1;
  assign nbl_dec = nbl_r - 4'd1;
  assign run_dec = run_r - 32'd1;
  assign acc16 = {48'd0, acc_r[7:0], b};
  assign acc32 = {32'd0, acc_r[23:0], b};
  assign lim_i = (int'(depth_r) > MAX_DEPTH) ? MAX_DEPTH : int'(depth_r);
  assign full  = (int'(level_r) >= lim_i);
  assign start = (st_r == S_IDLE) && q_valid && (!ov_r || res_ready);
  assign q_pop = start;
  assign res_valid = ov_r;
  assign res       = res_r;

  always_comb begin
    st_nxt = st_r; ph_nxt = ph_r; level_nxt = level_r; top_nxt = top_r;
    cur_nxt = cur_r; nbl_nxt = nbl_r; run_nxt = run_r; acc_nxt = acc_r;
    pos_nxt = pos_r; err_nxt = err_r; depth_nxt = depth_r;
    ppos_nxt = ppos_r; prole_nxt = prole_r; ptype_nxt = ptype_r;
    pval_nxt = pval_r; pvd_nxt = pvd_r; peod_nxt = peod_r;
    ov_nxt = ov_r; res_nxt = res_r;
    done = 1'b0; doc = 1'b0; e = ERR_NONE; errv = ERR_NONE;
    mem_we = 1'b0; mem_re = 1'b0; mem_wa = lvlm1[AW-1:0];
    mem_ra = lvlm2[AW-1:0]; mem_wd = top_r;

    if (cfg_we) depth_nxt = cfg_wdata;
    if (ov_r && res_ready) ov_nxt = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (start) begin
          ppos_nxt = pos_r; peod_nxt = q_item.eod;
          prole_nxt = ROLE_IGNORED; ptype_nxt = T_END;
          pval_nxt = 64'd0; pvd_nxt = 1'b0;
          if (err_r != ERR_NONE || ph_r == PH_HALT) begin
            done = 1'b1;
          end else begin
            case (ph_r)
              PH_ROOT, PH_CHILD: begin
                prole_nxt = ROLE_TYPE;
                if (q_item.bad_type) begin
                  e = ERR_TYPE; done = 1'b1;
                end else if (q_item.is_end) begin
                  if (ph_r == PH_CHILD) begin
                    // compound end: drop the frame, then continue upward
                    prole_nxt = ROLE_CEND;
                    if (level_r != '0) begin
                      level_nxt = lvlm1;
                      if (level_r > LW'(1)) begin
                        mem_re = 1'b1; st_nxt = S_WAIT;
                      end else st_nxt = S_FIN;
                    end else st_nxt = S_FIN;
                  end else begin
                    doc = 1'b1; done = 1'b1;
                  end
                end else begin
                  ptype_nxt = b[3:0]; cur_nxt = b[3:0]; ph_nxt = PH_NAMELEN;
                  nbl_nxt = 4'd2; acc_nxt = 64'd0; done = 1'b1;
                end
              end
              PH_NAMELEN, PH_STRLEN: begin
                prole_nxt = (ph_r == PH_NAMELEN) ? ROLE_NAMELEN : ROLE_STRLEN;
                ptype_nxt = cur_r; acc_nxt = acc16; nbl_nxt = nbl_dec;
                if (nbl_dec == 4'd0) begin
                  pval_nxt = acc16; pvd_nxt = 1'b1;
                  if (acc16[15]) begin
                    e = ERR_NEG; done = 1'b1;
                  end else if (acc16 == 64'd0) begin
                    st_nxt = (ph_r == PH_NAMELEN) ? S_BEGIN : S_FIN;
                  end else begin
                    run_nxt = acc16[31:0];
                    ph_nxt = (ph_r == PH_NAMELEN) ? PH_NAME : PH_STR;
                    done = 1'b1;
                  end
                end else done = 1'b1;
              end
              PH_NAME, PH_STR: begin
                prole_nxt = (ph_r == PH_NAME) ? ROLE_NAME : ROLE_STR;
                ptype_nxt = cur_r; run_nxt = run_dec;
                if (run_dec == 32'd0) st_nxt = (ph_r == PH_NAME) ? S_BEGIN : S_FIN;
                else done = 1'b1;
              end
              PH_SCALAR: begin
                prole_nxt = ROLE_SCALAR; ptype_nxt = cur_r;
                acc_nxt = {acc_r[55:0], b}; nbl_nxt = nbl_dec;
                if (nbl_dec == 4'd0) begin
                  pval_nxt = {acc_r[55:0], b}; pvd_nxt = 1'b1; st_nxt = S_FIN;
                end else done = 1'b1;
              end
              PH_LISTTYPE: begin
                prole_nxt = ROLE_LISTTYPE; ptype_nxt = T_LIST;
                run_nxt = {24'd0, b}; ph_nxt = PH_COUNT; nbl_nxt = 4'd4;
                acc_nxt = 64'd0; done = 1'b1;
              end
              PH_COUNT: begin
                prole_nxt = ROLE_COUNT; ptype_nxt = cur_r;
                acc_nxt = acc32; nbl_nxt = nbl_dec;
                if (nbl_dec == 4'd0) begin
                  pval_nxt = acc32; pvd_nxt = 1'b1;
                  if (acc32[31]) begin
                    e = ERR_NEG; done = 1'b1;
                  end else if (cur_r == T_LIST) begin
                    if (acc32 == 64'd0 || run_r == 32'd0) begin
                      st_nxt = S_FIN;
                    end else if (run_r > 32'd12) begin
                      e = ERR_TYPE; done = 1'b1;
                    end else if (full) begin
                      e = ERR_DEEP; done = 1'b1;
                    end else begin
                      // open the list frame, then start its first element
                      if (level_r != '0) mem_we = 1'b1;
                      top_nxt.is_list = 1'b1;
                      top_nxt.etype   = run_r[3:0];
                      top_nxt.left    = acc32[30:0] - 31'd1;
                      level_nxt = level_r + 1'b1;
                      cur_nxt = run_r[3:0];
                      st_nxt = S_BEGIN;
                    end
                  end else if (acc32 == 64'd0) begin
                    st_nxt = S_FIN;
                  end else begin
                    run_nxt = acc32[31:0]; ph_nxt = PH_ELEM;
                    nbl_nxt = elem_size(cur_r); acc_nxt = 64'd0; done = 1'b1;
                  end
                end else done = 1'b1;
              end
              PH_ELEM: begin
                prole_nxt = ROLE_ELEM; ptype_nxt = cur_r;
                acc_nxt = {acc_r[55:0], b}; nbl_nxt = nbl_dec;
                if (nbl_dec == 4'd0) begin
                  pval_nxt = {acc_r[55:0], b}; pvd_nxt = 1'b1; run_nxt = run_dec;
                  if (run_dec == 32'd0) st_nxt = S_FIN;
                  else begin
                    nbl_nxt = elem_size(cur_r); acc_nxt = 64'd0; done = 1'b1;
                  end
                end else done = 1'b1;
              end
              default: done = 1'b1;
            endcase
          end
        end
      end
      // a tag payload ended: continue in the enclosing frame
      S_FIN: begin
        if (level_r == '0) begin
          doc = 1'b1; ph_nxt = PH_ROOT; done = 1'b1;
        end else if (!top_r.is_list) begin
          ph_nxt = PH_CHILD; done = 1'b1;
        end else if (top_r.left != 31'd0) begin
          top_nxt.left = top_r.left - 31'd1;
          cur_nxt = top_r.etype; st_nxt = S_BEGIN;
        end else begin
          level_nxt = lvlm1;
          if (level_r > LW'(1)) begin
            mem_re = 1'b1; st_nxt = S_WAIT;
          end else st_nxt = S_FIN;
        end
      end
      S_WAIT: begin
        top_nxt = rd_data; st_nxt = S_FIN;
      end
      // start the payload of a tag of type cur_r
      S_BEGIN: begin
        acc_nxt = 64'd0; done = 1'b1;
        case (cur_r)
          T_BYTE:            begin ph_nxt = PH_SCALAR; nbl_nxt = 4'd1; end
          T_SHORT:           begin ph_nxt = PH_SCALAR; nbl_nxt = 4'd2; end
          T_INT, T_FLOAT:    begin ph_nxt = PH_SCALAR; nbl_nxt = 4'd4; end
          T_LONG, T_DOUBLE:  begin ph_nxt = PH_SCALAR; nbl_nxt = 4'd8; end
          T_BARRAY, T_IARRAY, T_LARRAY: begin ph_nxt = PH_COUNT; nbl_nxt = 4'd4; end
          T_STRING:          begin ph_nxt = PH_STRLEN; nbl_nxt = 4'd2; end
          T_LIST:            ph_nxt = PH_LISTTYPE;
          T_COMPOUND: begin
            ph_nxt = PH_CHILD;
            if (full) e = ERR_DEEP;
            else begin
              if (level_r != '0) mem_we = 1'b1;
              top_nxt = '0;
              level_nxt = level_r + 1'b1;
            end
          end
          default: e = ERR_TYPE;
        endcase
      end
      default: st_nxt = S_IDLE;
    endcase

    // close out the byte: latch errors, fill the result, advance or clear the position
    if (done) begin
      st_nxt = S_IDLE;
      errv = (e != ERR_NONE) ? e : err_r;
      if (e != ERR_NONE) begin
        err_nxt = e; ph_nxt = PH_HALT; doc = 1'b0;
      end
      if (errv == ERR_NONE && peod_nxt && !doc) errv = ERR_TRUNC;
      ov_nxt = 1'b1;
      res_nxt.position = ppos_nxt;
      res_nxt.role     = prole_nxt;
      res_nxt.ttype    = ptype_nxt;
      res_nxt.level    = 6'(level_nxt);
      res_nxt.value    = pval_nxt;
      res_nxt.vdone    = pvd_nxt;
      res_nxt.doc_done = doc;
      res_nxt.err      = errv;
      if (peod_nxt) begin
        level_nxt = '0; ph_nxt = PH_ROOT; cur_nxt = T_END; nbl_nxt = 4'd0;
        run_nxt = 32'd0; acc_nxt = 64'd0; pos_nxt = 32'd0; err_nxt = ERR_NONE;
      end else if (doc) begin
        pos_nxt = 32'd0; ph_nxt = PH_ROOT; level_nxt = '0;
      end else begin
        pos_nxt = pos_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= PH_ROOT; level_r <= '0; cur_r <= T_END;
      nbl_r <= 4'd0; run_r <= 32'd0; acc_r <= 64'd0; pos_r <= 32'd0;
      err_r <= ERR_NONE; depth_r <= DEPTH_RESET; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; level_r <= level_nxt; cur_r <= cur_nxt;
      nbl_r <= nbl_nxt; run_r <= run_nxt; acc_r <= acc_nxt; pos_r <= pos_nxt;
      err_r <= err_nxt; depth_r <= depth_nxt; ov_r <= ov_nxt;
    end
    top_r <= top_nxt;
    ppos_r <= ppos_nxt; prole_r <= prole_nxt; ptype_r <= ptype_nxt;
    pval_r <= pval_nxt; pvd_r <= pvd_nxt; peod_r <= peod_nxt;
    res_r <= res_nxt;
  end
endmodule
`default_nettype wire

@@ rtl/nbt_stream_tokenizer_top.sv @@
// A byte's result is registered when the byte is accepted into an idle back stage and the
// sequencer has passed S_FIN per payload end, S_BEGIN per payload start after a name or
// as a list element, and per popped frame S_FIN, after S_WAIT if from stack memory.
// Throughput: 1 byte per cycle for most bytes while out_tready is high; extra states
// stall the input once the 2-entry queue fills. Reset (rst_n low, synchronous) empties
// the queue and result register, sets depth_limit to 32; stack memory is not cleared.
`default_nettype none
module nbt_stream_tokenizer_top import nbt_pkg::*; #(
  parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [5:0]   cfg_wdata,   // depth_limit
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,    // data_byte
  input  wire logic         in_tlast,    // end_of_data
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // position[31:0], tag_type[35:32], nesting_level[41:36], value[105:42],
  // value_done[106], error_code[109:107], zero pad[111:110]
  output logic [111:0]      out_tdata,
  output logic [3:0]        out_tuser,   // byte_role
  output logic              out_tlast    // document_done
);
  logic    q_valid, q_pop;
  item_t   q_item;
  result_t res;

  nbt_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_valid, .q_item, .q_pop
  );

  nbt_parser #(.MAX_DEPTH(MAX_DEPTH)) u_parser (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .q_valid, .q_item, .q_pop,
    .res_valid(out_tvalid), .res, .res_ready(out_tready)
  );

  // pack the result onto the stream
  assign out_tdata = {2'b00, res.err, res.vdone, res.value, res.level,
                      res.ttype, res.position};
  assign out_tuser = res.role;
  assign out_tlast = res.doc_done;
endmodule
`default_nettype wire

@@ rtl/nbt_checker.sv @@
// Port-level checks of the tag tokenizer, bound to the top level.
// Depends on nbt_pkg and nbt_stream_tokenizer_top_macros.svh.
`default_nettype none
`include "nbt_stream_tokenizer_top_macros.svh"
module nbt_checker import nbt_pkg::*; (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [111:0] out_tdata,
  input wire logic [3:0]   out_tuser,
  input wire logic         out_tlast
);
  // stalled result holds
  `NBT_ASSERT_RST(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  // a completed document carries no error
  `NBT_ASSERT_RST(a_doc_ok, out_tvalid && out_tlast |-> out_tdata[109:107] == ERR_NONE, "document done with error")
  // ignored bytes complete no number
  `NBT_ASSERT_RST(a_ign_val, out_tvalid && out_tuser == ROLE_IGNORED |-> !out_tdata[106], "value on ignored byte")
  // no result right after reset
  `NBT_ASSERT_ALL(a_rst, !rst_n |=> !out_tvalid, "result valid after reset")
endmodule

bind nbt_stream_tokenizer_top nbt_checker u_nbt_checker (.*);
`default_nettype wire

@@ test/nbt_stream_tokenizer_top_test.sv @@
// Self-checking testbench for the streaming tag tokenizer top level.
// Depends on nbt_pkg and nbt_stream_tokenizer_top. Generates tag documents and checks
// each per-byte result against a built-in predictor.
`default_nettype none
module nbt_stream_tokenizer_top_test import nbt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 1820;

  typedef enum logic [3:0] {
    PS_ROOT, PS_CHILD, PS_NAMELEN, PS_NAME, PS_SCALAR, PS_STRLEN, PS_STR,
    PS_LISTTYPE, PS_COUNT, PS_ELEM, PS_HALT
  } parse_phase_t;

  // directed request: byte, end flag, and typed role/error where obvious
  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    logic [3:0] role;
    logic [2:0] err;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [5:0]   cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;

  nbt_stream_tokenizer_top DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  // tokenizer state as predicted
  logic [5:0]   tk_limit;
  logic         tk_islist [32];
  logic [3:0]   tk_etype  [32];
  logic [30:0]  tk_left   [32];
  int unsigned  tk_level;
  parse_phase_t tk_phase;
  logic [3:0]   tk_type;
  int           tk_nleft;
  logic [31:0]  tk_run;
  logic [63:0]  tk_acc;
  logic [31:0]  tk_pos;
  logic [2:0]   tk_err;
  bit           tk_docdone;

  result_t      token_q [$];
  logic [7:0]   doc_q [$];
  int           mismatches;
  int           results_seen;
  int           docs_sent;
  int           snd_idle;
  int           rcv_idle;
  int           quiet_cycles;

  // clock and receiver stalls
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle);
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got 0x%0h expected 0x%0h (result %0d)", what, got, want,
             results_seen);
    mismatches++;
  endtask

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_t want;
      if (token_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[63:0], 0);
      end else begin
        want = token_q.pop_front();
        if (out_tdata[31:0] != want.position)
          report_mismatch("position", out_tdata[31:0], want.position);
        if (out_tuser != want.role) report_mismatch("byte_role", out_tuser, want.role);
        if (out_tdata[35:32] != want.ttype)
          report_mismatch("tag_type", out_tdata[35:32], want.ttype);
        if (out_tdata[41:36] != want.level)
          report_mismatch("nesting_level", out_tdata[41:36], want.level);
        if (out_tdata[105:42] != want.value)
          report_mismatch("value", out_tdata[105:42], want.value);
        if (out_tdata[106] != want.vdone)
          report_mismatch("value_done", out_tdata[106], want.vdone);
        if (out_tlast != want.doc_done)
          report_mismatch("document_done", out_tlast, want.doc_done);
        if (out_tdata[109:107] != want.err)
          report_mismatch("error_code", out_tdata[109:107], want.err);
      end
      results_seen++;
    end
  end

  // watchdog: cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- predictor ----------------
  function automatic void clear_parse();
    tk_level = 0;
    tk_phase = PS_ROOT;
    tk_type  = T_END;
    tk_nleft = 0;
    tk_run   = 0;
    tk_acc   = 0;
    tk_pos   = 0;
    tk_err   = ERR_NONE;
  endfunction

  function automatic logic [2:0] open_frame(logic is_list, logic [3:0] et,
                                            logic [30:0] left);
    int unsigned lim;
    lim = (tk_limit > 32) ? 32 : tk_limit;
    if (tk_level >= lim) return ERR_DEEP;
    tk_islist[tk_level] = is_list;
    tk_etype[tk_level]  = et;
    tk_left[tk_level]   = left;
    tk_level++;
    return ERR_NONE;
  endfunction

  function automatic int elem_bytes(logic [3:0] t);
    return (t == T_BARRAY) ? 1 : ((t == T_IARRAY) ? 4 : 8);
  endfunction

  function automatic logic [2:0] start_payload(logic [3:0] t);
    tk_type = t;
    tk_acc  = 0;
    case (t)
      T_BYTE: begin tk_phase = PS_SCALAR; tk_nleft = 1; end
      T_SHORT: begin tk_phase = PS_SCALAR; tk_nleft = 2; end
      T_INT, T_FLOAT: begin tk_phase = PS_SCALAR; tk_nleft = 4; end
      T_LONG, T_DOUBLE: begin tk_phase = PS_SCALAR; tk_nleft = 8; end
      T_BARRAY, T_IARRAY, T_LARRAY: begin tk_phase = PS_COUNT; tk_nleft = 4; end
      T_STRING: begin tk_phase = PS_STRLEN; tk_nleft = 2; end
      T_LIST: tk_phase = PS_LISTTYPE;
      T_COMPOUND: begin
        tk_phase = PS_CHILD;
        return open_frame(1'b0, T_END, '0);
      end
      default: return ERR_TYPE;
    endcase
    return ERR_NONE;
  endfunction

  // payload complete: resume in enclosing frame, unwinding finished lists
  function automatic logic [2:0] close_payload();
    int unsigned top;
    while (tk_level > 0) begin
      top = tk_level - 1;
      if (!tk_islist[top]) begin
        tk_phase = PS_CHILD;
        return ERR_NONE;
      end
      if (tk_left[top] != 0) begin
        tk_left[top] = tk_left[top] - 1;
        return start_payload(tk_etype[top]);
      end
      tk_level--;
    end
    tk_docdone = 1'b1;
    tk_phase = PS_ROOT;
    return ERR_NONE;
  endfunction

  function automatic result_t tokenize_byte(logic [7:0] b, logic eod);
    result_t r;
    logic [2:0] e;
    logic [31:0] cnt;
    r = '0;
    r.position = tk_pos;
    r.role = ROLE_IGNORED;
    r.ttype = T_END;
    r.err = ERR_NONE;
    e = ERR_NONE;
    tk_docdone = 1'b0;
    if (tk_err != ERR_NONE || tk_phase == PS_HALT) begin
      r.err = tk_err;
    end else begin
      case (tk_phase)
        PS_ROOT, PS_CHILD: begin
          r.role = ROLE_TYPE;
          if (b > 12) begin
            e = ERR_TYPE;
          end else if (b == 0) begin
            if (tk_phase == PS_CHILD) begin
              r.role = ROLE_CEND;
              if (tk_level > 0) tk_level--;
              e = close_payload();
            end else begin
              tk_docdone = 1'b1;
            end
          end else begin
            r.ttype = b[3:0];
            tk_type = b[3:0];
            tk_phase = PS_NAMELEN;
            tk_nleft = 2;
            tk_acc = 0;
          end
        end
        PS_NAMELEN, PS_STRLEN: begin
          r.role = (tk_phase == PS_NAMELEN) ? ROLE_NAMELEN : ROLE_STRLEN;
          r.ttype = tk_type;
          tk_acc = {48'd0, tk_acc[7:0], b};
          tk_nleft--;
          if (tk_nleft == 0) begin
            r.value = tk_acc;
            r.vdone = 1'b1;
            if (tk_acc[15]) e = ERR_NEG;
            else if (tk_acc == 0)
              e = (tk_phase == PS_NAMELEN) ? start_payload(tk_type) : close_payload();
            else begin
              tk_run = tk_acc[31:0];
              tk_phase = (tk_phase == PS_NAMELEN) ? PS_NAME : PS_STR;
            end
          end
        end
        PS_NAME, PS_STR: begin
          r.role = (tk_phase == PS_NAME) ? ROLE_NAME : ROLE_STR;
          r.ttype = tk_type;
          tk_run--;
          if (tk_run == 0)
            e = (tk_phase == PS_NAME) ? start_payload(tk_type) : close_payload();
        end
        PS_SCALAR: begin
          r.role = ROLE_SCALAR;
          r.ttype = tk_type;
          tk_acc = {tk_acc[55:0], b};
          tk_nleft--;
          if (tk_nleft == 0) begin
            r.value = tk_acc;
            r.vdone = 1'b1;
            e = close_payload();
          end
        end
        PS_LISTTYPE: begin
          r.role = ROLE_LISTTYPE;
          r.ttype = T_LIST;
          tk_run = {24'd0, b};
          tk_phase = PS_COUNT;
          tk_nleft = 4;
          tk_acc = 0;
        end
        PS_COUNT: begin
          r.role = ROLE_COUNT;
          r.ttype = tk_type;
          tk_acc = {32'd0, tk_acc[23:0], b};
          tk_nleft--;
          if (tk_nleft == 0) begin
            cnt = tk_acc[31:0];
            r.value = tk_acc;
            r.vdone = 1'b1;
            if (cnt[31]) begin
              e = ERR_NEG;
            end else if (tk_type == T_LIST) begin
              if (cnt == 0 || tk_run == 0) e = close_payload();
              else if (tk_run > 12) e = ERR_TYPE;
              else begin
                e = open_frame(1'b1, tk_run[3:0], cnt[30:0] - 31'd1);
                if (e == ERR_NONE) e = start_payload(tk_run[3:0]);
              end
            end else if (cnt == 0) begin
              e = close_payload();
            end else begin
              tk_run = cnt;
              tk_phase = PS_ELEM;
              tk_nleft = elem_bytes(tk_type);
              tk_acc = 0;
            end
          end
        end
        PS_ELEM: begin
          r.role = ROLE_ELEM;
          r.ttype = tk_type;
          tk_acc = {tk_acc[55:0], b};
          tk_nleft--;
          if (tk_nleft == 0) begin
            r.value = tk_acc;
            r.vdone = 1'b1;
            tk_run--;
            if (tk_run == 0) e = close_payload();
            else begin
              tk_nleft = elem_bytes(tk_type);
              tk_acc = 0;
            end
          end
        end
        default: ;
      endcase
      if (e != ERR_NONE) begin
        tk_err = e;
        r.err = e;
        tk_phase = PS_HALT;
        tk_docdone = 1'b0;
      end
    end
    if (r.err == ERR_NONE && eod && !tk_docdone) r.err = ERR_TRUNC;
    r.level = tk_level[5:0];
    r.doc_done = tk_docdone;
    if (eod) begin
      clear_parse();
    end else if (tk_docdone) begin
      tk_pos = 0;
      tk_phase = PS_ROOT;
      tk_level = 0;
    end else begin
      tk_pos = tk_pos + 1;
    end
    return r;
  endfunction

  // ---------------- stimulus ----------------
  // send one byte; prediction is made when the request is accepted
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed = 0,
                           input logic [3:0] role = ROLE_TYPE,
                           input logic [2:0] err = ERR_NONE);
    result_t r;
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    r = tokenize_byte(b, last);
    if (typed) begin
      r.role = role;
      r.err  = err;
    end
    token_q.insert(token_q.size(), r);
  endtask

  // quiesce, then write the depth limit
  task automatic set_depth(input logic [5:0] v);
    in_tvalid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tk_limit = v;
  endtask

  // append one byte to the document under construction
  task automatic put_byte(input logic [7:0] v);
    doc_q.insert(doc_q.size(), v);
  endtask

  task automatic put_rand(input int n);
    repeat (n) put_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put16(input int v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endtask

  task automatic put32(input int v);
    put_byte(v[31:24]);
    put_byte(v[23:16]);
    put16(v);
  endtask

  function automatic int rand_type(input int d);
    return (d > 3) ? $urandom_range(1, 8) : $urandom_range(1, 12);
  endfunction

  task automatic gen_payload(input int t, input int d, input int chain);
    int n;
    int et;
    case (t)
      T_BYTE: put_rand(1);
      T_SHORT: put_rand(2);
      T_INT, T_FLOAT: put_rand(4);
      T_LONG, T_DOUBLE: put_rand(8);
      T_BARRAY, T_IARRAY, T_LARRAY: begin
        n = $urandom_range(0, 3);
        put32(n);
        put_rand(n * elem_bytes(t[3:0]));
      end
      T_STRING: begin
        n = $urandom_range(0, 4);
        put16(n);
        put_rand(n);
      end
      T_LIST: begin
        if (chain > 0) begin
          et = $urandom_range(0, 1) ? T_COMPOUND : T_LIST;
          n = 1;
        end else begin
          et = ($urandom_range(0, 9) == 0) ? T_END : rand_type(d);
          n = $urandom_range(0, 3);
        end
        put_byte(et[7:0]);
        put32(n);
        if (et != T_END)
          repeat (n) gen_payload(et, d + 1, (chain > 0) ? chain - 1 : 0);
      end
      T_COMPOUND: begin
        if (chain > 0) gen_tag($urandom_range(0, 1) ? T_COMPOUND : T_LIST, d + 1, chain - 1);
        repeat ($urandom_range(0, (d > 3) ? 1 : 3)) gen_tag(rand_type(d), d + 1, 0);
        put_byte({4'd0, T_END});
      end
      default: ;
    endcase
  endtask

  task automatic gen_tag(input int t, input int d, input int chain);
    int n;
    put_byte(t[7:0]);
    n = $urandom_range(0, 3);
    put16(n);
    put_rand(n);
    gen_payload(t, d, chain);
  endtask

  // one random document, sent whole, damaged, cut short or replaced by noise
  task automatic send_document(output int sent);
    int mode;
    int cut;
    doc_q.delete();
    case ($urandom_range(0, 9))
      0: put_byte({4'd0, T_END});
      1, 2: gen_tag(rand_type(0), 1, 0);
      3: gen_tag(T_COMPOUND, 0, $urandom_range(1, 35));
      default: gen_tag(T_COMPOUND, 0, 0);
    endcase
    mode = $urandom_range(0, 9);
    if (mode == 7) begin
      doc_q[$urandom_range(0, doc_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (mode == 8) begin
      cut = $urandom_range(1, doc_q.size());
      while (doc_q.size() > cut) void'(doc_q.pop_back());
    end else if (mode == 9) begin
      doc_q.delete();
      put_rand($urandom_range(1, 12));
    end
    sent = doc_q.size();
    foreach (doc_q[i])
      send_byte(doc_q[i], (i == doc_q.size() - 1) && (mode >= 7 || mode == 0));
    docs_sent++;
  endtask

  dir_row_t directed_rows [] = '{
    '{8'h00, 1'b0, 1, ROLE_TYPE,    ERR_NONE},   // empty root document
    '{8'h0D, 1'b0, 1, ROLE_TYPE,    ERR_TYPE},   // type code out of range
    '{8'hFF, 1'b1, 1, ROLE_IGNORED, ERR_TYPE},   // error stays until end of data
    '{8'h0A, 1'b0, 0, ROLE_TYPE,    ERR_NONE},   // root compound, empty name
    '{8'h00, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h00, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h01, 1'b0, 0, ROLE_TYPE,    ERR_NONE},   // byte tag named "a"
    '{8'h00, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h01, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h61, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'hFF, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h09, 1'b0, 0, ROLE_TYPE,    ERR_NONE},   // list of two bytes
    '{8'h00, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h00, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h01, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h00, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h00, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h00, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h02, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h80, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h7F, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h00, 1'b0, 1, ROLE_CEND,    ERR_NONE},   // closes root compound
    '{8'h08, 1'b0, 0, ROLE_TYPE,    ERR_NONE},   // string with negative name length
    '{8'h80, 1'b0, 0, ROLE_TYPE,    ERR_NONE},
    '{8'h00, 1'b0, 1, ROLE_NAMELEN, ERR_NEG},
    '{8'h00, 1'b1, 1, ROLE_IGNORED, ERR_NEG},
    '{8'h03, 1'b1, 1, ROLE_TYPE,    ERR_TRUNC}   // cut off after type byte
  };

  // ---------------- main sequence ----------------
  initial begin
    logic [5:0] depth_plan [6];
    int sent;
    int total;
    int quota;
    depth_plan = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd2, 6'd32};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    mismatches = 0;
    results_seen = 0;
    docs_sent = 0;
    quiet_cycles = 0;
    snd_idle = 24;
    rcv_idle = 63;
    tk_limit = DEPTH_RESET;
    clear_parse();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].role, directed_rows[i].err);

    total = 0;
    for (int p = 0; p < 6; p++) begin
      snd_idle = (p < 2) ? 24 : ((p < 4) ? 63 : 0);
      rcv_idle = (p < 2) ? 63 : ((p < 4) ? 24 : 0);
      set_depth((p == 4) ? 6'($urandom_range(3, 31)) : depth_plan[p]);
      quota = RANDOM_ITEMS * (p + 1) / 6;
      while (total < quota) begin
        send_document(sent);
        total += sent;
      end
      // leave the phase with the parser back at its starting state
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      total++;
    end

    in_tvalid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d random bytes in %0d documents, %0d results checked",
             total, docs_sent, results_seen);
    $display("six depth settings, three stall patterns, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
